### hdl/binary_to_decimal_ascii_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII converter
// Each macro puts one concurrent assertion, sampled on clk and disabled
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define B2DA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b2da check failed");

// antecedent implies consequent in the next cycle
`define B2DA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b2da check failed");

`endif

### hdl/b2da_pkg.sv
// ---------------------------------------------------------------------------
// b2da_pkg
// Request and result types and fixed constants of the decimal converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

    localparam logic [5:0] ASCII_ZERO_C = 6'h30;
    localparam logic [5:0] ASCII_NINE_C = 6'h39;

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  min_digits;
    } src_t;

    typedef struct packed {
        logic [5:0] ascii_digit;
        logic       is_last;
        logic [3:0] digit_count;
    } dst_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

### hdl/binary_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to ASCII decimal characters, most
// significant first, padded with leading zeros up to a minimum count.
// ---------------------------------------------------------------------------
// Usage:
//   src channel: one request carries value and min_digits. src_stall is
//   high while a conversion is in progress; a request is taken only when
//   the converter is idle.
//   dst channel: one result per character; is_last marks the final one and
//   carries the character count in digit_count (zero on other results).
//   Timing: the request's bits run through a chain of BCD digit cells, one
//   bit per cycle. A sizing step then fixes the character count, and one
//   character is loaded per cycle the output register is free. Once the
//   last character is loaded the next request is taken, even if that
//   character still waits in the output register.
//   Reset: clears the sequencer and the output valid; no clearing pass.
//   Stall on dst holds the output register and pauses character loading.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 10
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic src_valid,
    output logic src_stall,
    input  src_t src_data,
    output logic dst_valid,
    input  logic dst_stall,
    output dst_t dst_data
);

    // decimal digits needed for VALUE_BITS bits
    localparam int NCELLS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int ND     = (NCELLS > MAX_DIGITS) ? NCELLS : MAX_DIGITS;
    localparam int PW     = $clog2(ND);
    localparam int NW     = PW + 1;
    localparam int MW     = (NW > 4) ? NW : 4;
    localparam int BW     = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic [BW-1:0]         bits_reg;
    logic [BW-1:0]         bits_next;
    logic [3:0]            min_reg;
    logic [3:0]            min_next;
    logic [NW-1:0]         n_reg;
    logic [NW-1:0]         n_next;
    logic [PW-1:0]         pos_reg;
    logic [PW-1:0]         pos_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    dst_t                  out_reg;
    dst_t                  out_next;

    logic       accept;
    logic       slot_free;
    cell_ctrl_t ctrl;
    logic [3:0] dig [ND];
    logic [NCELLS:0] carry;
    logic [NW-1:0] nsig;
    logic [MW-1:0] nsig_w;
    logic [MW-1:0] min_w;
    logic [MW-1:0] lim_w;
    logic [MW-1:0] n_w;
    logic [3:0]    cur_digit;

    assign accept    = src_valid && !src_stall;
    assign src_stall = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !dst_stall;
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

    assign ctrl.clear = accept;
    assign ctrl.shift = (state_reg == ST_CONV);

    // feed the value MSB first into the lowest digit cell
    assign carry[0] = val_reg[VALUE_BITS-1];

    for (genvar i = 0; i < ND; i++)
    begin : g_cells
        if (i < NCELLS)
        begin : g_live
            b2da_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (carry[i]),
                .carry_out (carry[i+1]),
                .digit     (dig[i])
            );
        end
        else
        begin : g_pad
            assign dig[i] = 4'd0;
        end
    end

    // position of the highest nonzero digit, at least one digit
    always_comb
    begin
        nsig = NW'(1);
        for (int i = 0; i < NCELLS; i++)
        begin
            if (dig[i] != 4'd0)
            begin
                nsig = NW'(i + 1);
            end
        end
    end

    always_comb
    begin
        nsig_w = MW'(nsig);
        min_w  = MW'(min_reg);
        lim_w  = MW'(MAX_DIGITS);
        if (nsig_w > lim_w)
        begin
            nsig_w = lim_w;
        end
        if (min_w > lim_w)
        begin
            min_w = lim_w;
        end
        n_w = (min_w > nsig_w) ? min_w : nsig_w;
    end

    assign cur_digit = dig[pos_reg];

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        bits_next      = bits_reg;
        min_next       = min_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !dst_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next   = VALUE_BITS'(src_data.value);
                    min_next   = src_data.min_digits;
                    bits_next  = BW'(VALUE_BITS);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                val_next  = {val_reg[VALUE_BITS-2:0], 1'b0};
                bits_next = bits_reg - BW'(1);
                if (bits_reg == BW'(1))
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                n_next     = NW'(n_w);
                pos_next   = PW'(n_w - MW'(1));
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.ascii_digit = ASCII_ZERO_C + {2'b00, cur_digit};
                    out_next.is_last     = (pos_reg == '0);
                    out_next.digit_count = (pos_reg == '0) ? 4'(n_reg) : 4'd0;
                    pos_next             = pos_reg - PW'(1);
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        min_reg <= min_next;
        n_reg   <= n_next;
        pos_reg <= pos_next;
        out_reg <= out_next;
    end

endmodule

### hdl/b2da_cell.sv
// ---------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the double dabble chain: add three at five or more,
// then shift one bit in from the lower neighbor.
// ---------------------------------------------------------------------------
module b2da_cell
    import b2da_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       carry_in,
    output logic       carry_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[2:0], carry_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### hdl/b2da_check.sv
// ---------------------------------------------------------------------------
// b2da_check
// Port-level checks of the decimal converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "binary_to_decimal_ascii_assert.svh"

module b2da_check
    import b2da_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic src_valid,
    input logic src_stall,
    input src_t src_data,
    input logic dst_valid,
    input logic dst_stall,
    input dst_t dst_data
);

    `B2DA_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_data))
    `B2DA_ASSERT_NEXT(a_busy_after_req, src_valid && !src_stall, src_stall)
    `B2DA_ASSERT_NOW(a_char_range, dst_valid, (dst_data.ascii_digit >= ASCII_ZERO_C) && (dst_data.ascii_digit <= ASCII_NINE_C))
    `B2DA_ASSERT_NOW(a_count_last, dst_valid, dst_data.is_last == (dst_data.digit_count != 4'd0))

endmodule

bind binary_to_decimal_ascii b2da_check u_check (.*);
